FILE: rtl/fpalu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpalu_pkg
// Shared types and helpers for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpalu_pkg;

    typedef enum logic [3:0] {
        FN_ADD     = 4'd0,
        FN_SUB     = 4'd1,
        FN_MUL     = 4'd2,
        FN_DIV     = 4'd3,
        FN_GT      = 4'd4,
        FN_LT      = 4'd5,
        FN_GE      = 4'd6,
        FN_LE      = 4'd7,
        FN_EQ      = 4'd8,
        FN_NE      = 4'd9,
        FN_MIN     = 4'd10,
        FN_MAX     = 4'd11,
        FN_INC     = 4'd12,
        FN_DEC     = 4'd13,
        FN_TOINT   = 4'd14,
        FN_FROMINT = 4'd15
    } func_t;

    // per-item sideband that rides along the divider cells
    typedef struct packed {
        func_t       func;
        logic        neg;
        logic        dz;
        logic [63:0] prod;
        logic [31:0] res;
        logic        cmp;
        logic        sat;
    } side_t;

    localparam int SIDE_W = $bits(side_t);

    // clamp a magnitude with sign to 32-bit signed, returns {sat, value}
    function automatic logic [32:0] clamp_mag(input logic [64:0] m, input logic neg);
        logic [64:0] lim;
        logic [64:0] mm;
        logic        s;
        lim = neg ? 65'h0_8000_0000 : 65'h0_7FFF_FFFF;
        s   = m > lim;
        mm  = s ? lim : m;
        return {s, (neg ? (32'd0 - mm[31:0]) : mm[31:0])};
    endfunction

endpackage
`default_nettype wire

FILE: rtl/fixed_point_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed fixed-point ALU on 32-bit raw values with FRAC_BITS fraction bits.
//
// Input channel (in_valid/in_ready) transfers func, operand_a, operand_b.
// Output channel (out_valid/out_ready) transfers result_value, compare_true,
// saturated and divide_by_zero, one result per input, in order.
// Every item walks the same pipeline: an operand stage, a row of
// 32+FRAC_BITS division cells (one quotient bit per cell), and a rounding
// and clamping output register. Throughput is one item per cycle while
// the receiver keeps taking results.
// The 32x32 multiplier sits between the operand stage and the first cell.
// When the receiver stalls with a result held, the whole pipeline freezes
// and in_ready drops; it resumes the cycle the result is taken.
// Reset clears all valid bits; no result is pending after reset.
// ----------------------------------------------------------------------------
module fixed_point_alu
    import fpalu_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [3:0]         func,
    input  wire logic signed [31:0] operand_a,
    input  wire logic signed [31:0] operand_b,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      result_value,
    output logic                    compare_true,
    output logic                    saturated,
    output logic                    divide_by_zero
);

    localparam int DW = 32 + FRAC_BITS;
    localparam int NC = DW;

    logic en;

    // operand stage
    func_t       fn;
    logic [31:0] amag;
    logic [31:0] bmag;
    logic [32:0] sum;
    logic [32:0] dif;
    logic [32:0] incs;
    logic [32:0] decs;
    logic [DW-1:0] fi_ext;
    logic        fi_ok;
    logic [31:0] ti_mag;
    side_t       side_next;

    logic        pre_valid_reg;
    side_t       pre_side_reg;
    logic [31:0] amag_reg;
    logic [31:0] bmag_reg;

    assign fn   = func_t'(func);
    assign amag = operand_a[31] ? (32'd0 - operand_a) : operand_a;
    assign bmag = operand_b[31] ? (32'd0 - operand_b) : operand_b;
    assign sum  = {operand_a[31], operand_a} + {operand_b[31], operand_b};
    assign dif  = {operand_a[31], operand_a} - {operand_b[31], operand_b};
    assign incs = {operand_a[31], operand_a} + 33'd1;
    assign decs = {operand_a[31], operand_a} - 33'd1;
    assign fi_ext = {operand_a, {FRAC_BITS{1'b0}}};
    assign fi_ok  = (&fi_ext[DW-1:31]) | ~(|fi_ext[DW-1:31]);
    assign ti_mag = amag >> FRAC_BITS;

    // signed 33-bit clamp to 32 bits
    function automatic logic [32:0] sat33(input logic [32:0] v);
        logic ovf;
        ovf = v[32] != v[31];
        return {ovf, (ovf ? (v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : v[31:0])};
    endfunction

    always_comb
    begin
        side_next      = '0;
        side_next.func = fn;
        side_next.neg  = operand_a[31] ^ operand_b[31];
        side_next.dz   = operand_b == 32'sd0;
        case (fn)
            FN_ADD:     {side_next.sat, side_next.res} = sat33(sum);
            FN_SUB:     {side_next.sat, side_next.res} = sat33(dif);
            FN_GT:      side_next.cmp = operand_a > operand_b;
            FN_LT:      side_next.cmp = operand_a < operand_b;
            FN_GE:      side_next.cmp = operand_a >= operand_b;
            FN_LE:      side_next.cmp = operand_a <= operand_b;
            FN_EQ:      side_next.cmp = operand_a == operand_b;
            FN_NE:      side_next.cmp = operand_a != operand_b;
            FN_MIN:     side_next.res = (operand_a < operand_b) ? operand_a : operand_b;
            FN_MAX:     side_next.res = (operand_a > operand_b) ? operand_a : operand_b;
            FN_INC:     {side_next.sat, side_next.res} = sat33(incs);
            FN_DEC:     {side_next.sat, side_next.res} = sat33(decs);
            FN_TOINT:   side_next.res = operand_a[31] ? (32'd0 - ti_mag) : ti_mag;
            FN_FROMINT:
            begin
                side_next.sat = ~fi_ok;
                side_next.res = fi_ok ? fi_ext[31:0]
                              : (operand_a[31] ? 32'h8000_0000 : 32'h7FFF_FFFF);
            end
            default:    side_next.res = '0;
        endcase
    end

    assign en       = ~out_valid | out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pre_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_side_reg <= side_next;
            amag_reg     <= amag;
            bmag_reg     <= bmag;
        end
    end

    // multiplier feeds the first cell's sideband register
    side_t cell0_side;
    always_comb
    begin
        cell0_side      = pre_side_reg;
        cell0_side.prod = amag_reg * bmag_reg;
    end

    logic          c_valid [NC+1];
    logic [DW-1:0] c_dvd   [NC+1];
    logic [31:0]   c_rem   [NC+1];
    logic [DW-1:0] c_quo   [NC+1];
    logic [31:0]   c_div   [NC+1];
    side_t         c_side  [NC+1];

    assign c_valid[0] = pre_valid_reg;
    assign c_dvd[0]   = {amag_reg, {FRAC_BITS{1'b0}}};
    assign c_rem[0]   = '0;
    assign c_quo[0]   = '0;
    assign c_div[0]   = bmag_reg;
    assign c_side[0]  = cell0_side;

    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        fpalu_div_cell #(
            .DW(DW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (c_valid[i]),
            .dvd_in    (c_dvd[i]),
            .rem_in    (c_rem[i]),
            .quo_in    (c_quo[i]),
            .div_in    (c_div[i]),
            .side_in   (c_side[i]),
            .valid_out (c_valid[i+1]),
            .dvd_out   (c_dvd[i+1]),
            .rem_out   (c_rem[i+1]),
            .quo_out   (c_quo[i+1]),
            .div_out   (c_div[i+1]),
            .side_out  (c_side[i+1])
        );
    end

    // rounding and clamping
    side_t       fs;
    logic [64:0] mul_mag;
    logic [64:0] div_mag;
    logic        div_up;
    logic [32:0] mul_cl;
    logic [32:0] div_cl;
    logic [31:0] res_next;
    logic        sat_next;
    logic        dz_next;

    assign fs      = c_side[NC];
    assign mul_mag = ({1'b0, fs.prod} + (65'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign div_up  = {c_rem[NC], 1'b0} >= {1'b0, c_div[NC]};
    assign div_mag = {{(65-DW){1'b0}}, c_quo[NC]} + {64'd0, div_up};
    assign mul_cl  = clamp_mag(mul_mag, fs.neg);
    assign div_cl  = clamp_mag(div_mag, fs.neg);

    always_comb
    begin
        res_next = fs.res;
        sat_next = fs.sat;
        dz_next  = 1'b0;
        case (fs.func)
            FN_MUL:
            begin
                res_next = mul_cl[31:0];
                sat_next = mul_cl[32];
            end
            FN_DIV:
            begin
                dz_next  = fs.dz;
                res_next = fs.dz ? 32'd0 : div_cl[31:0];
                sat_next = fs.dz ? 1'b0 : div_cl[32];
            end
            default: ;
        endcase
    end

    logic        out_valid_reg;
    logic [31:0] res_reg;
    logic        cmp_reg;
    logic        sat_reg;
    logic        dz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= c_valid[NC];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
            cmp_reg <= fs.cmp;
            sat_reg <= sat_next;
            dz_reg  <= dz_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_value   = res_reg;
    assign compare_true   = cmp_reg;
    assign saturated      = sat_reg;
    assign divide_by_zero = dz_reg;

endmodule
`default_nettype wire

FILE: rtl/fpalu_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpalu_div_cell
// One restoring-division cell: retires one quotient bit per item and hands
// the partial remainder, dividend and sideband to the next cell.
// ----------------------------------------------------------------------------
module fpalu_div_cell
    import fpalu_pkg::*;
#(
    parameter int DW = 40
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          valid_in,
    input  wire logic [DW-1:0] dvd_in,
    input  wire logic [31:0]   rem_in,
    input  wire logic [DW-1:0] quo_in,
    input  wire logic [31:0]   div_in,
    input  wire side_t         side_in,
    output logic               valid_out,
    output logic [DW-1:0]      dvd_out,
    output logic [31:0]        rem_out,
    output logic [DW-1:0]      quo_out,
    output logic [31:0]        div_out,
    output side_t              side_out
);

    logic        valid_reg;
    logic [32:0] trial;
    logic        ge;
    logic [32:0] diff;
    logic [31:0] rem_next;

    assign trial    = {rem_in, dvd_in[DW-1]};
    assign ge       = trial >= {1'b0, div_in};
    assign diff     = trial - {1'b0, div_in};
    assign rem_next = ge ? diff[31:0] : trial[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvd_out  <= {dvd_in[DW-2:0], 1'b0};
            rem_out  <= rem_next;
            quo_out  <= {quo_in[DW-2:0], ge};
            div_out  <= div_in;
            side_out <= side_in;
        end
    end

    assign valid_out = valid_reg;

endmodule
`default_nettype wire

FILE: bench/fixed_point_alu_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_alu_checker
// Watches both channels of the fixed-point ALU, computes the expected result
// of every input transfer and compares each output transfer against it.
// ----------------------------------------------------------------------------
module fixed_point_alu_checker
    import fpalu_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic [3:0]         func,
    input  wire logic signed [31:0] operand_a,
    input  wire logic signed [31:0] operand_b,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic signed [31:0] result_value,
    input  wire logic               compare_true,
    input  wire logic               saturated,
    input  wire logic               divide_by_zero,
    output int                      errors,
    output int                      pending
);

    typedef struct packed {
        logic signed [31:0] value;
        logic               cmp;
        logic               sat;
        logic               dz;
    } alu_result_t;

    alu_result_t expected_results[$];

    function automatic alu_result_t clamp_wide(input logic signed [127:0] v);
        alu_result_t r;
        r = '0;
        if (v > 128'sd2147483647)
        begin
            r.value = 32'h7FFF_FFFF;
            r.sat   = 1'b1;
        end
        else if (v < -128'sd2147483648)
        begin
            r.value = 32'h8000_0000;
            r.sat   = 1'b1;
        end
        else
            r.value = v[31:0];
        return r;
    endfunction

    function automatic alu_result_t compute_alu(input func_t f, input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        alu_result_t        r;
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic        [127:0] ma;
        logic        [127:0] mb;
        logic        [127:0] q;
        logic        [127:0] rem;
        logic                neg;
        r   = '0;
        wa  = a;
        wb  = b;
        ma  = (wa < 0) ? -wa : wa;
        mb  = (wb < 0) ? -wb : wb;
        neg = (a < 0) != (b < 0);
        case (f)
            FN_ADD:  r = clamp_wide(wa + wb);
            FN_SUB:  r = clamp_wide(wa - wb);
            FN_MUL:
            begin
                q = (ma * mb + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                r = clamp_wide(neg ? -$signed(q) : $signed(q));
            end
            FN_DIV:
            begin
                if (b == 0)
                    r.dz = 1'b1;
                else
                begin
                    q   = (ma << FRAC_BITS) / mb;
                    rem = (ma << FRAC_BITS) % mb;
                    if (rem * 2 >= mb)
                        q = q + 1;
                    r = clamp_wide(neg ? -$signed(q) : $signed(q));
                end
            end
            FN_GT:   r.cmp = a > b;
            FN_LT:   r.cmp = a < b;
            FN_GE:   r.cmp = a >= b;
            FN_LE:   r.cmp = a <= b;
            FN_EQ:   r.cmp = a == b;
            FN_NE:   r.cmp = a != b;
            FN_MIN:  r.value = (a < b) ? a : b;
            FN_MAX:  r.value = (a > b) ? a : b;
            FN_INC:  r = clamp_wide(wa + 1);
            FN_DEC:  r = clamp_wide(wa - 1);
            FN_TOINT:
            begin
                q = ma >> FRAC_BITS;
                r.value = (a < 0) ? -q[31:0] : q[31:0];
            end
            default: r = clamp_wide(wa * (128'sd1 <<< FRAC_BITS));
        endcase
        return r;
    endfunction

    assign pending = expected_results.size();

    initial errors = 0;

    always @(posedge clk)
    begin
        alu_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors <= errors + 1;
                    $display("%0t: unexpected result transfer, actual %h", $time,
                             result_value);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.value !== result_value || want.cmp !== compare_true ||
                        want.sat !== saturated || want.dz !== divide_by_zero)
                    begin
                        errors <= errors + 1;
                        $display({"%0t: mismatch expected %h cmp %b sat %b dz %b,",
                                  " actual %h cmp %b sat %b dz %b"},
                                 $time, want.value, want.cmp, want.sat, want.dz,
                                 result_value, compare_true, saturated, divide_by_zero);
                    end
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(compute_alu(func_t'(func), operand_a, operand_b));
        end
    end

endmodule
`default_nettype wire

FILE: bench/tb_fixed_point_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_fixed_point_alu
// Drives directed corner operations and then random mixes of all sixteen
// functions into the fixed-point ALU, with random idling on both sides and
// one long output hold-off that fills the pipeline; a checker scores results.
// ----------------------------------------------------------------------------
module tb_fixed_point_alu;
    import fpalu_pkg::*;

    localparam int FRAC_BITS    = 8;
    localparam int RANDOM_ITEMS = 1900;
    localparam int TAIL_ITEMS   = 300;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 34 + FRAC_BITS + 20;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [3:0]         func;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] result_value;
    logic               compare_true;
    logic               saturated;
    logic               divide_by_zero;
    int                 errors;
    int                 pending;
    int                 idle_cycles;
    bit                 quiet_phase;
    bit                 holdoff_done;

    fixed_point_alu #(.FRAC_BITS(FRAC_BITS)) dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .operand_a(operand_a), .operand_b(operand_b),
        .out_valid(out_valid), .out_ready(out_ready), .result_value(result_value),
        .compare_true(compare_true), .saturated(saturated),
        .divide_by_zero(divide_by_zero)
    );

    fixed_point_alu_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .operand_a(operand_a), .operand_b(operand_b),
        .out_valid(out_valid), .out_ready(out_ready), .result_value(result_value),
        .compare_true(compare_true), .saturated(saturated),
        .divide_by_zero(divide_by_zero), .errors(errors), .pending(pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 8)) - 4);
            3: return 32'($signed($urandom_range(0, 65535)) - 32768);
            4: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
            default: return $urandom;
        endcase
    endfunction

    // one transfer on the input channel, with an optional idle burst first
    task automatic send_op(input func_t f, input logic [31:0] a, input logic [31:0] b);
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            for (gap = $urandom_range(1, 4); gap > 0; gap--)
                @(negedge clk);
        end
        in_valid  <= 1'b1;
        func      <= f;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // receiver: random stall bursts, one long hold-off
    initial
    begin
        int n;
        out_ready    = 1'b0;
        holdoff_done = 1'b0;
        @(posedge rst_n);
        repeat (30) @(negedge clk);
        out_ready <= 1'b0;
        for (n = 0; n < 150; n++)
            @(negedge clk);
        holdoff_done = 1'b1;
        forever
        begin
            out_ready <= 1'b1;
            for (n = $urandom_range(1, 8); n > 0; n--)
                @(negedge clk);
            if (!quiet_phase)
            begin
                out_ready <= 1'b0;
                for (n = $urandom_range(1, 4); n > 0; n--)
                    @(negedge clk);
            end
        end
    end

    // watchdog on transfers
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int i;
        int wait_cycles;
        func_t f;
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        func        = '0;
        operand_a   = '0;
        operand_b   = '0;
        idle_cycles = 0;
        quiet_phase = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_op(FN_ADD, 32'h7FFF_FFFF, 32'd1);
        send_op(FN_SUB, 32'h8000_0000, 32'd1);
        send_op(FN_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_op(FN_MUL, 32'h8000_0000, 32'h8000_0000);
        send_op(FN_MUL, 32'd384, 32'hFFFF_FF80);
        send_op(FN_DIV, 32'd1000, 32'd0);
        send_op(FN_DIV, 32'h8000_0000, 32'd1);
        send_op(FN_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        send_op(FN_DIV, 32'd1, 32'd512);
        send_op(FN_DIV, 32'hFFFF_FFFF, 32'd512);
        send_op(FN_GT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_op(FN_LT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_op(FN_GE, 32'd5, 32'd5);
        send_op(FN_LE, 32'd6, 32'd5);
        send_op(FN_EQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(FN_NE, 32'd0, 32'd0);
        send_op(FN_MIN, 32'd7, 32'd7);
        send_op(FN_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
        send_op(FN_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_op(FN_DEC, 32'h8000_0000, 32'd0);
        send_op(FN_TOINT, 32'hFFFF_FF01, 32'd0);
        send_op(FN_TOINT, 32'h8000_0000, 32'd0);
        send_op(FN_FROMINT, 32'h0080_0000, 32'd0);
        send_op(FN_FROMINT, 32'hFF7F_FFFF, 32'd0);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - TAIL_ITEMS)
            begin
                while (!holdoff_done)
                    @(negedge clk);
                quiet_phase = 1'b1;
            end
            f = func_t'($urandom_range(0, 15));
            send_op(f, pick_operand(), pick_operand());
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        for (wait_cycles = 0; wait_cycles < DRAIN_CYCLES; wait_cycles++)
            @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire
